// ===== hw/rtl/assert_macros.svh =====
// Concurrent assertion helpers, clocked on clk, disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mdf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mdf_pkg;

  localparam int FIELD_W = 16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED_A,
    S_RED_B,
    S_LOOP,
    S_WAIT_INV,
    S_WAIT_SQ,
    S_WAIT_FIN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mdf_mulmod.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mdf_mulmod #(
  parameter int MOD_WIDTH = 16,
  parameter int OP_WIDTH  = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 req,
  input  wire logic [OP_WIDTH-1:0]  x,
  input  wire logic [OP_WIDTH-1:0]  y,
  input  wire logic [MOD_WIDTH-1:0] p,
  output mdf_pkg::mm_sts_t          sts,
  output logic      [MOD_WIDTH-1:0] res
);

  localparam int PW = 2 * OP_WIDTH;
  localparam int CW = $clog2(PW);

  logic [PW-1:0]        prod_r;
  logic [MOD_WIDTH-1:0] rem_r;
  logic [MOD_WIDTH-1:0] rem_nxt;
  logic [CW-1:0]        cnt_r;
  logic                 run_r;
  logic                 done_r;
  logic [MOD_WIDTH:0]   shifted;
  logic [MOD_WIDTH:0]   diff;

  // restoring remainder, one product bit per cycle
  always_comb begin
    shifted = {rem_r, prod_r[PW-1]};
    diff    = shifted - {1'b0, p};
    rem_nxt = (shifted >= {1'b0, p}) ? diff[MOD_WIDTH-1:0] : shifted[MOD_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req) begin
        run_r <= 1'b1;
      end else if (run_r && (cnt_r == '0)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req) begin
      prod_r <= x * y;
      rem_r  <= '0;
      cnt_r  <= CW'(PW - 1);
    end else if (run_r) begin
      prod_r <= prod_r << 1;
      rem_r  <= rem_nxt;
      cnt_r  <= cnt_r - 1'b1;
    end
  end

  assign sts.busy = run_r;
  assign sts.done = done_r;
  assign res      = rem_r;

endmodule

`default_nettype wire

// ===== hw/rtl/modular_divider_fermat_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Modular division q = a * b^(p-2) mod p, p the modulus register.
// Input: pulse start while busy is low; in_dividend and in_divisor are taken
// at that edge. busy stays high until the result has been shown.
// Output: out_valid is high for exactly one cycle with out_quotient and
// out_no_inverse; the receiver cannot stall, so the result must be taken then.
// out_no_inverse is set (quotient 0) when the divisor reduces to 0 mod p or
// p is below 2.
// Config: cfg_valid/cfg_ready write cfg_data into the modulus; cfg_ready is
// low while busy or while start is high. Reset sets the modulus to 97 and the
// block idle.
// Cost: every modular product runs through one shared unit, a multiply
// followed by 2*W serial reduction steps, W = max(MOD_WIDTH, 16). An item
// costs (3 + n + k) products, n the bit length of p-2 and k its ones count
// (one product less when p-2 is nonzero, since the top bit's square is
// skipped). One item at a time.
module modular_divider_fermat_core #(
  parameter int MOD_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [mdf_pkg::FIELD_W-1:0]   in_dividend,
  input  wire logic [mdf_pkg::FIELD_W-1:0]   in_divisor,
  output logic                               out_valid,
  output logic      [mdf_pkg::FIELD_W-1:0]   out_quotient,
  output logic                               out_no_inverse,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [MOD_WIDTH-1:0]          cfg_data
);

  localparam int OW = (MOD_WIDTH > mdf_pkg::FIELD_W) ? MOD_WIDTH : mdf_pkg::FIELD_W;
  localparam logic [MOD_WIDTH-1:0] P_RESET = MOD_WIDTH'(97);

  mdf_pkg::state_t  state_r;
  mdf_pkg::state_t  state_nxt;
  mdf_pkg::mm_sts_t mm_sts;

  logic [MOD_WIDTH-1:0]        p_r;
  logic [mdf_pkg::FIELD_W-1:0] b_r;
  logic [MOD_WIDTH-1:0]        a_r;
  logic [MOD_WIDTH-1:0]        base_r;
  logic [MOD_WIDTH-1:0]        inv_r;
  logic [MOD_WIDTH-1:0]        e_r;
  logic [MOD_WIDTH-1:0]        q_r;
  logic                        nf_r;
  logic                        mm_req;
  logic [OW-1:0]               op_x;
  logic [OW-1:0]               op_y;
  logic [MOD_WIDTH-1:0]        mm_res;
  logic [OW-1:0]               q_ext;
  logic                        p_small;
  logic                        e_last;

  assign p_small = (p_r < MOD_WIDTH'(2));
  assign e_last  = ((e_r >> 1) == '0);

  mdf_mulmod #(
    .MOD_WIDTH (MOD_WIDTH),
    .OP_WIDTH  (OW)
  ) u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .x     (op_x),
    .y     (op_y),
    .p     (p_r),
    .sts   (mm_sts),
    .res   (mm_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mdf_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = p_small ? mdf_pkg::S_OUT : mdf_pkg::S_RED_A;
        end
      end
      mdf_pkg::S_RED_A: begin
        if (mm_sts.done) begin
          state_nxt = mdf_pkg::S_RED_B;
        end
      end
      mdf_pkg::S_RED_B: begin
        if (mm_sts.done) begin
          state_nxt = (mm_res == '0) ? mdf_pkg::S_OUT : mdf_pkg::S_LOOP;
        end
      end
      mdf_pkg::S_LOOP: begin
        if (e_r == '0) begin
          state_nxt = mdf_pkg::S_WAIT_FIN;
        end else if (e_r[0]) begin
          state_nxt = mdf_pkg::S_WAIT_INV;
        end else begin
          state_nxt = mdf_pkg::S_WAIT_SQ;
        end
      end
      mdf_pkg::S_WAIT_INV: begin
        if (mm_sts.done) begin
          state_nxt = e_last ? mdf_pkg::S_LOOP : mdf_pkg::S_WAIT_SQ;
        end
      end
      mdf_pkg::S_WAIT_SQ: begin
        if (mm_sts.done) begin
          state_nxt = mdf_pkg::S_LOOP;
        end
      end
      mdf_pkg::S_WAIT_FIN: begin
        if (mm_sts.done) begin
          state_nxt = mdf_pkg::S_OUT;
        end
      end
      mdf_pkg::S_OUT: begin
        state_nxt = mdf_pkg::S_IDLE;
      end
      default: begin
        state_nxt = mdf_pkg::S_IDLE;
      end
    endcase
  end

  // unit requests and operand select
  always_comb begin
    mm_req = 1'b0;
    op_x   = '0;
    op_y   = '0;
    case (state_r)
      mdf_pkg::S_IDLE: begin
        mm_req = start && !p_small;
        op_x   = OW'(in_dividend);
        op_y   = OW'(1);
      end
      mdf_pkg::S_RED_A: begin
        mm_req = mm_sts.done;
        op_x   = OW'(b_r);
        op_y   = OW'(1);
      end
      mdf_pkg::S_LOOP: begin
        mm_req = 1'b1;
        if (e_r == '0) begin
          op_x = OW'(a_r);
          op_y = OW'(inv_r);
        end else if (e_r[0]) begin
          op_x = OW'(inv_r);
          op_y = OW'(base_r);
        end else begin
          op_x = OW'(base_r);
          op_y = OW'(base_r);
        end
      end
      mdf_pkg::S_WAIT_INV: begin
        mm_req = mm_sts.done && !e_last;
        op_x   = OW'(base_r);
        op_y   = OW'(base_r);
      end
      default: begin
        mm_req = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mdf_pkg::S_IDLE;
      p_r     <= P_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        p_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      mdf_pkg::S_IDLE: begin
        b_r  <= in_divisor;
        q_r  <= '0;
        nf_r <= 1'b1;
      end
      mdf_pkg::S_RED_A: begin
        if (mm_sts.done) begin
          a_r <= mm_res;
        end
      end
      mdf_pkg::S_RED_B: begin
        base_r <= mm_res;
        inv_r  <= MOD_WIDTH'(1);
        e_r    <= p_r - MOD_WIDTH'(2);
      end
      mdf_pkg::S_WAIT_INV: begin
        if (mm_sts.done) begin
          inv_r <= mm_res;
          if (e_last) begin
            e_r <= '0;
          end
        end
      end
      mdf_pkg::S_WAIT_SQ: begin
        if (mm_sts.done) begin
          base_r <= mm_res;
          e_r    <= e_r >> 1;
        end
      end
      mdf_pkg::S_WAIT_FIN: begin
        if (mm_sts.done) begin
          q_r  <= mm_res;
          nf_r <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign q_ext          = OW'(q_r);
  assign busy           = (state_r != mdf_pkg::S_IDLE);
  // no modulus write on the edge that takes a beat
  assign cfg_ready      = !busy && !start;
  assign out_valid      = (state_r == mdf_pkg::S_OUT);
  assign out_quotient   = q_ext[mdf_pkg::FIELD_W-1:0];
  assign out_no_inverse = nf_r;

  `ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted beat did not raise busy")
  `ASSERT_NEXT(a_out_idle, out_valid, !busy && !out_valid, "result strobe not single or not idle after")
  `ASSERT_IMPL(a_req_free, mm_req, !mm_sts.busy, "product requested while unit running")
  `ASSERT_IMPL(a_q_range, out_valid && !out_no_inverse, q_r < p_r, "quotient not below modulus")

endmodule

`default_nettype wire

// ===== tb/modular_divider_fermat_core_tb.sv =====
`timescale 1ns / 1ps

module modular_divider_fermat_core_tb;

  localparam int W = mdf_pkg::FIELD_W;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned END_DRAIN = 40;

  localparam int MOD_RAND_SMALL = -1;
  localparam int MOD_RAND_FULL = -2;
  localparam int N_PHASES = 16;
  localparam int PHASE_MOD [N_PHASES] = '{97, 13, 2, 3, 251, 65521, 65535, 1009, 4096, 7,
                                          MOD_RAND_SMALL, MOD_RAND_FULL, 0, 1, 32749, 5};
  localparam int PHASE_LEN [N_PHASES] = '{200, 150, 60, 80, 200, 60, 50, 200, 60, 150,
                                          200, 60, 10, 10, 60, 50};
  localparam int RAND_TOTAL = 1600;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic [W-1:0] quotient;
    logic         no_inverse;
  } div_result_t;

  typedef struct packed {
    row_kind_t    kind;
    logic [W-1:0] modulus;
    logic [W-1:0] dividend;
    logic [W-1:0] divisor;
    bit           typed;
    logic [W-1:0] quotient;
    logic         no_inverse;
  } dir_row_t;

  localparam int N_DIR = 28;
  dir_row_t dir_rows [N_DIR] = '{
    // reset modulus 97
    '{ROW_ITEM, 16'd0,     16'd0,     16'd1,     1'b1, 16'd0, 1'b0},
    '{ROW_ITEM, 16'd0,     16'd5,     16'd1,     1'b1, 16'd5, 1'b0},
    '{ROW_ITEM, 16'd0,     16'hFFFF,  16'hFFFF,  1'b1, 16'd1, 1'b0},
    '{ROW_ITEM, 16'd0,     16'd1234,  16'd0,     1'b1, 16'd0, 1'b1},
    '{ROW_ITEM, 16'd0,     16'hFFFF,  16'd97,    1'b1, 16'd0, 1'b1},
    '{ROW_ITEM, 16'd0,     16'd0,     16'd194,   1'b1, 16'd0, 1'b1},
    '{ROW_ITEM, 16'd0,     16'd77,    16'd33,    1'b0, 16'd0, 1'b0},
    '{ROW_ITEM, 16'd0,     16'd96,    16'd96,    1'b1, 16'd1, 1'b0},
    // smallest field, exponent zero
    '{ROW_CFG,  16'd2,     16'd0,     16'd0,     1'b0, 16'd0, 1'b0},
    '{ROW_ITEM, 16'd0,     16'd1,     16'd1,     1'b1, 16'd1, 1'b0},
    '{ROW_ITEM, 16'd0,     16'hFFFF,  16'd3,     1'b1, 16'd1, 1'b0},
    '{ROW_ITEM, 16'd0,     16'd4,     16'hFFFF,  1'b1, 16'd0, 1'b0},
    '{ROW_ITEM, 16'd0,     16'd3,     16'd0,     1'b1, 16'd0, 1'b1},
    // largest 16-bit prime
    '{ROW_CFG,  16'd65521, 16'd0,     16'd0,     1'b0, 16'd0, 1'b0},
    '{ROW_ITEM, 16'd0,     16'hFFFF,  16'hFFFE,  1'b0, 16'd0, 1'b0},
    '{ROW_ITEM, 16'd0,     16'd65520, 16'd65520, 1'b1, 16'd1, 1'b0},
    '{ROW_ITEM, 16'd0,     16'd12345, 16'd65521, 1'b1, 16'd0, 1'b1},
    '{ROW_ITEM, 16'd0,     16'd1,     16'd2,     1'b0, 16'd0, 1'b0},
    // all-ones modulus, not prime
    '{ROW_CFG,  16'hFFFF,  16'd0,     16'd0,     1'b0, 16'd0, 1'b0},
    '{ROW_ITEM, 16'd0,     16'hFFFF,  16'hFFFF,  1'b1, 16'd0, 1'b1},
    '{ROW_ITEM, 16'd0,     16'd7,     16'd3,     1'b0, 16'd0, 1'b0},
    '{ROW_ITEM, 16'd0,     16'h8000,  16'h7FFF,  1'b0, 16'd0, 1'b0},
    // no usable field, then back to modulus 3
    '{ROW_CFG,  16'd1,     16'd0,     16'd0,     1'b0, 16'd0, 1'b0},
    '{ROW_ITEM, 16'd0,     16'd5,     16'd7,     1'b1, 16'd0, 1'b1},
    '{ROW_CFG,  16'd0,     16'd0,     16'd0,     1'b0, 16'd0, 1'b0},
    '{ROW_ITEM, 16'd0,     16'd9,     16'd9,     1'b1, 16'd0, 1'b1},
    '{ROW_CFG,  16'd3,     16'd0,     16'd0,     1'b0, 16'd0, 1'b0},
    '{ROW_ITEM, 16'd0,     16'd1,     16'd2,     1'b0, 16'd0, 1'b0}
  };

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         start = 1'b0;
  logic         busy;
  logic [W-1:0] in_dividend = '0;
  logic [W-1:0] in_divisor = '0;
  logic         out_valid;
  logic [W-1:0] out_quotient;
  logic         out_no_inverse;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [15:0]  cfg_data = '0;

  // expectation carried alongside a directed beat
  logic         row_typed = 1'b0;
  logic [W-1:0] row_quotient = '0;
  logic         row_no_inverse = 1'b0;

  div_result_t  quotient_q [$];
  logic [15:0]  modulus_now = 16'd97;
  int unsigned  send_idle_pct = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  mismatches = 0;
  int unsigned  divisions_done = 0;
  int unsigned  flagged_done = 0;
  int unsigned  modulus_writes = 0;

  always #10 clk = ~clk;

  modular_divider_fermat_core #(.MOD_WIDTH(16)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_dividend    (in_dividend),
    .in_divisor     (in_divisor),
    .out_valid      (out_valid),
    .out_quotient   (out_quotient),
    .out_no_inverse (out_no_inverse),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  // a * b^(p-2) mod p by right-to-left square-and-multiply
  function automatic div_result_t fermat_quotient(input logic [W-1:0] a, input logic [W-1:0] b,
                                                  input logic [15:0] p);
    div_result_t r;
    bit [31:0] pw, x, base, inv, e;
    r.quotient = '0;
    r.no_inverse = 1'b1;
    pw = 32'(p);
    if (pw < 2) return r;
    x = 32'(a) % pw;
    base = 32'(b) % pw;
    if (base == 0) return r;
    inv = 1;
    e = pw - 2;
    while (e != 0) begin
      if (e[0]) inv = (inv * base) % pw;
      base = (base * base) % pw;
      e = e >> 1;
    end
    r.quotient = W'((x * inv) % pw);
    r.no_inverse = 1'b0;
    return r;
  endfunction

  function automatic void pick_operands(input int unsigned p, output logic [W-1:0] a,
                                        output logic [W-1:0] b);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    a = W'($urandom);
    b = W'($urandom);
    case (sel)
      0: if (p >= 2) b = W'(p * $urandom_range(0, 65535 / p));
      1: a = ($urandom_range(0, 1) != 0) ? '1 : '0;
      2: if (p >= 2) begin
        a = W'($urandom_range(0, p - 1));
        b = W'($urandom_range(1, p - 1));
      end
      3: b = ($urandom_range(0, 1) != 0) ? '1 : W'(1);
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want_v,
                                 input int unsigned got_v);
    $display("MISMATCH %s: expected %0d, got %0d (t=%0t)", what, want_v, got_v, $realtime);
    mismatches++;
  endtask

  task automatic send_division(input logic [W-1:0] a, input logic [W-1:0] b, input bit typed,
                               input logic [W-1:0] q, input logic ni);
    while (($urandom % 100) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_dividend <= a;
    in_divisor <= b;
    row_typed <= typed;
    row_quotient <= q;
    row_no_inverse <= ni;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [15:0] value);
    start <= 1'b0;
    do @(posedge clk); while (quotient_q.size() != 0);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : scoreboard
    div_result_t want;
    if (rst_n) begin
      quiet_cycles = quiet_cycles + 1;
      if (cfg_valid && cfg_ready) begin
        modulus_now = cfg_data;
        modulus_writes++;
        quiet_cycles = 0;
      end
      if (start && !busy) begin
        if (row_typed) want = '{quotient: row_quotient, no_inverse: row_no_inverse};
        else want = fermat_quotient(in_dividend, in_divisor, modulus_now);
        quotient_q = {quotient_q, want};
        quiet_cycles = 0;
      end
      if (out_valid) begin
        quiet_cycles = 0;
        divisions_done++;
        if (out_no_inverse) flagged_done++;
        if (quotient_q.size() == 0) begin
          report_mismatch("result beat with nothing pending, quotient", 0, out_quotient);
        end else begin
          want = quotient_q.pop_front();
          if (out_quotient !== want.quotient)
            report_mismatch("quotient", want.quotient, out_quotient);
          if (out_no_inverse !== want.no_inverse)
            report_mismatch("no_inverse", want.no_inverse, out_no_inverse);
        end
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int unsigned p;
    int unsigned rand_sent;
    logic [W-1:0] a, b;
    rand_sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 23;
    for (int i = 0; i < N_DIR; i++) begin
      if (dir_rows[i].kind == ROW_CFG) write_modulus(dir_rows[i].modulus);
      else send_division(dir_rows[i].dividend, dir_rows[i].divisor, dir_rows[i].typed,
                         dir_rows[i].quotient, dir_rows[i].no_inverse);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (PHASE_MOD[ph] == MOD_RAND_SMALL) p = $urandom_range(4, 1023);
      else if (PHASE_MOD[ph] == MOD_RAND_FULL) p = $urandom_range(2, 65535);
      else p = PHASE_MOD[ph];
      write_modulus(p[15:0]);
      for (int n = 0; n < PHASE_LEN[ph]; n++) begin
        if (rand_sent < RAND_TOTAL / 3) send_idle_pct = 23;
        else if (rand_sent < 2 * RAND_TOTAL / 3) send_idle_pct = 82;
        else send_idle_pct = 0;
        pick_operands(p, a, b);
        send_division(a, b, 1'b0, '0, 1'b0);
        rand_sent++;
      end
    end

    start <= 1'b0;
    do @(posedge clk); while (quotient_q.size() != 0);
    repeat (END_DRAIN) @(posedge clk);

    $display("Checked %0d divisions (%0d without inverse) over %0d modulus writes,",
             divisions_done, flagged_done, modulus_writes);
    $display("moduli 0..65535 incl. primes, composites and random picks; sender gaps 23/82/0%%.");
    if (mismatches == 0 && quotient_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      if (quotient_q.size() != 0)
        report_mismatch("results never delivered, count", 0, quotient_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/mdf_pkg.sv
hw/rtl/mdf_mulmod.sv
hw/rtl/modular_divider_fermat_core.sv
tb/modular_divider_fermat_core_tb.sv
